FILE: rtl/gf_chien_search_evaluator_macros.svh
// Assertion macros shared by the checker of the Chien search evaluator
`ifndef GF_CHIEN_SEARCH_EVALUATOR_MACROS_SVH
`define GF_CHIEN_SEARCH_EVALUATOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GFCSE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gfcse: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define GFCSE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gfcse: next-cycle check failed");

`endif

FILE: rtl/gfcse_pkg.sv
// Types, constants and GF(2^8) helpers of the Chien search evaluator
`timescale 1ns / 1ps

package gfcse_pkg;

  localparam int GF_FIELD_SIZE = 256;
  localparam int GF_ORDER      = GF_FIELD_SIZE - 1;
  localparam logic [7:0] GF_MASK = 8'hb8;
  localparam int MAX_DEGREE    = 16;
  localparam int COEF_IDX_W    = $clog2(MAX_DEGREE + 1);

  // Request kinds carried in tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_FIRST_LOCATION = 2'd0;
  localparam logic [1:0] CFG_LOCATION_COUNT = 2'd1;
  localparam logic [1:0] CFG_POLY_DEGREE    = 2'd2;

  typedef logic [7:0] vec_table_t [GF_FIELD_SIZE];

  typedef struct packed {
    logic load;      // store one coefficient, restart the location count
    logic start;     // latch step data for a new evaluation
    logic step;      // fold one term into the accumulator
    logic out_load;  // move the finished result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic last_term; // current term is the highest one in use
  } dp_status_t;

  // Antilog table: exponent code e+1 -> vector form, code 0 -> 0
  function automatic vec_table_t build_exp_table();
    vec_table_t tab;
    logic [7:0] v;
    logic c;
    tab[0] = 8'd0;
    v = 8'(GF_FIELD_SIZE >> 1);
    for (int e = 0; e < GF_ORDER; e++) begin
      c = v[0];
      v = v >> 1;
      if (c) begin
        v = v ^ GF_MASK;
      end
      tab[e + 1] = v;
    end
    return tab;
  endfunction

  localparam vec_table_t EXP_TO_VEC = build_exp_table();

  // (a + b) mod GF_ORDER for a + b below twice GF_ORDER
  function automatic logic [7:0] mod_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return (sum >= 9'(GF_ORDER)) ? 8'(sum - 9'(GF_ORDER)) : sum[7:0];
  endfunction

endpackage

FILE: rtl/gfcse_ctrl.sv
// Sequencer of the Chien search evaluator: request intake, term loop, output hold
`timescale 1ns / 1ps

module gfcse_ctrl
  import gfcse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [1:0] {S_IDLE, S_ACC, S_FLUSH} state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.load     = accept && (in_op == OP_LOAD);
    cmd.start    = accept && (in_op == OP_EVAL);
    cmd.step     = (state == S_ACC);
    cmd.out_load = (state == S_FLUSH) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.start) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (status.last_term) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (cmd.out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/gfcse_datapath.sv
// Datapath of the Chien search evaluator: registers, coefficient store, term unit
`timescale 1ns / 1ps

module gfcse_datapath
  import gfcse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  input  logic [COEF_IDX_W-1:0] in_index,
  input  logic [7:0]            in_value,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  output logic [7:0]            out_eval,
  output logic [7:0]            out_slot,
  output logic                  out_last
);

  logic [7:0] first_location;
  logic [7:0] location_count;
  logic [4:0] poly_degree;

  logic [7:0] coef [MAX_DEGREE + 1];
  logic [7:0] step_count;

  logic [7:0]            step_exp;   // (x exponent + l) mod order
  logic [7:0]            term_pow;   // i * step_exp mod order
  logic [COEF_IDX_W-1:0] term_idx;
  logic [7:0]            acc;
  logic [7:0]            slot;
  logic                  last;

  logic [COEF_IDX_W-1:0] deg_clamped;
  logic [7:0]            a;
  logic [7:0]            term_code;

  always_comb begin
    if (poly_degree > 5'(MAX_DEGREE)) begin
      deg_clamped = COEF_IDX_W'(MAX_DEGREE);
    end else begin
      deg_clamped = COEF_IDX_W'(poly_degree);
    end
  end

  assign status.last_term = (term_idx == deg_clamped);

  assign a = coef[term_idx];

  always_comb begin
    if (term_idx == '0) begin
      term_code = a;
    end else if (a != 8'd0 && first_location != 8'd0) begin
      term_code = mod_add(a - 8'd1, term_pow) + 8'd1;
    end else begin
      term_code = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_location <= 8'd1;
      location_count <= 8'd254;
      poly_degree    <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_LOCATION: first_location <= cfg_data;
        CFG_LOCATION_COUNT: location_count <= cfg_data;
        CFG_POLY_DEGREE:    poly_degree    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= MAX_DEGREE; k++) begin
        coef[k] <= 8'd0;
      end
      step_count <= 8'd0;
    end else if (cmd.load) begin
      if (in_index <= COEF_IDX_W'(MAX_DEGREE)) begin
        coef[in_index] <= in_value;
        step_count     <= 8'd0;
      end
    end else if (cmd.start) begin
      if (step_count < location_count) begin
        step_count <= step_count + 8'd1;
      end else begin
        step_count <= 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      step_exp <= mod_add(first_location - 8'd1, step_count);
      term_pow <= 8'd0;
      term_idx <= '0;
      acc      <= 8'd0;
      if (step_count < location_count) begin
        slot <= location_count - step_count;
        last <= 1'b0;
      end else begin
        slot <= 8'd0;
        last <= 1'b1;
      end
    end else if (cmd.step) begin
      acc      <= acc ^ EXP_TO_VEC[term_code];
      term_pow <= mod_add(term_pow, step_exp);
      term_idx <= term_idx + COEF_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_eval <= acc;
      out_slot <= slot;
      out_last <= last;
    end
  end

endmodule

FILE: rtl/gf_chien_search_evaluator.sv
// Chien search evaluator over GF(2^8): top level with stream and config ports
// Evaluation: an accepted evaluate request walks terms 0..D through the datapath,
//   D = min(poly_degree, 16); the shared term unit folds one coefficient per cycle.
// Intake: a new request is taken only while idle, once the previous one is done.
// Reset: synchronous, active high; clears coefficients, step count, output valid,
//   and sets first_location 1, location_count 254, poly_degree 0.
`timescale 1ns / 1ps

module gf_chien_search_evaluator
  import gfcse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [4:0] coef_index, [12:5] coef_value, zero fill
  input  logic [0:0]  s_axis_tuser,   // [0] op
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] eval_value, [15:8] slot_index
  output logic        m_axis_tlast    // last
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [7:0] out_eval;
  logic [7:0] out_slot;
  logic       out_last;

  // The sequencer takes one request at a time: a load writes the coefficient
  // store in its accept cycle, an evaluate walks terms 0..D through the datapath
  // and then waits until the output register is free.
  gfcse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser[0]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  // Term exponents advance by a constant step each cycle, so no multiplier is
  // needed: term i uses i * (x + l) mod 255 built by repeated modular adds.
  gfcse_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_index  (s_axis_tdata[COEF_IDX_W-1:0]),
    .in_value  (s_axis_tdata[12:5]),
    .cmd       (cmd),
    .status    (status),
    .out_eval  (out_eval),
    .out_slot  (out_slot),
    .out_last  (out_last)
  );

  // Output register holds the result until the consumer takes it
  assign m_axis_tdata = {out_slot, out_eval};
  assign m_axis_tlast = out_last;

endmodule

FILE: rtl/gfcse_checker.sv
// Port-level assertions of the Chien search evaluator and their bind
`timescale 1ns / 1ps
`include "gf_chien_search_evaluator_macros.svh"

module gfcse_checker
  import gfcse_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A stalled result holds its payload
  `GFCSE_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // The final location of a run always lands in slot zero
  `GFCSE_ASSERT_IMP(a_last_slot, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tdata[15:8] == 8'd0)

  // Reset leaves no result pending
  `GFCSE_ASSERT_IMP(a_reset_empty, clk, rst, $past(rst), !m_axis_tvalid)

  // An evaluate request occupies the block on the following cycle
  `GFCSE_ASSERT_NXT(a_eval_busy, clk, rst, s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_EVAL), !s_axis_tready)

endmodule

bind gf_chien_search_evaluator gfcse_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
